// File: sv/round_robin_thread_slot_scheduler_top_assert.svh
`ifndef ROUND_ROBIN_THREAD_SLOT_SCHEDULER_TOP_ASSERT_SVH
`define ROUND_ROBIN_THREAD_SLOT_SCHEDULER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define RRTS_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rrts check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define RRTS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rrts check failed");

`endif

// File: sv/rrts_pkg.sv
package rrts_pkg;

  localparam int SLOTS_DEF = 16;

  // commands
  localparam logic [2:0] CMD_YIELD  = 3'd0;
  localparam logic [2:0] CMD_CREATE = 3'd1;
  localparam logic [2:0] CMD_EXIT   = 3'd2;
  localparam logic [2:0] CMD_JOIN   = 3'd3;
  localparam logic [2:0] CMD_QUERY  = 3'd4;

  // result status
  localparam logic [2:0] STS_OK           = 3'd0;
  localparam logic [2:0] STS_NO_FREE      = 3'd1;
  localparam logic [2:0] STS_BAD_TARGET   = 3'd2;
  localparam logic [2:0] STS_ROOT_EXIT    = 3'd3;
  localparam logic [2:0] STS_NONE_READY   = 3'd4;
  localparam logic [2:0] STS_JOIN_PENDING = 3'd5;
  localparam logic [2:0] STS_JOIN_NEVER   = 3'd6;

  // slot states
  localparam logic [1:0] ST_FREE  = 2'd0;
  localparam logic [1:0] ST_READY = 2'd1;
  localparam logic [1:0] ST_DEAD  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_STACK_DEFAULT = 3'd0;
  localparam logic [2:0] CFG_STACK_MIN     = 3'd1;
  localparam logic [2:0] CFG_STACK_MAX     = 3'd2;
  localparam logic [2:0] CFG_HOG_LIMIT     = 3'd3;
  localparam logic [2:0] CFG_HOG_REPORTS   = 3'd4;

  localparam logic [31:0] STACK_ROUND = 32'd15;
  localparam logic [20:0] GRANT_SAT   = 21'h1FFFF0;

  typedef struct packed {
    logic [20:0] stack_default;
    logic [20:0] stack_min;
    logic [20:0] stack_max;
    logic [31:0] hog_limit;
    logic [7:0]  hog_report_limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    stack_default:    21'd8192,
    stack_min:        21'd4096,
    stack_max:        21'd65536,
    hog_limit:        32'd1000,
    hog_report_limit: 8'd8
  };

  typedef struct packed {
    logic        sub;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] sum;
    logic        carry;
  } alu_rsp_t;

  typedef struct packed {
    logic        we_state;
    logic        we_resume;
    logic        we_start;
    logic [1:0]  state;
    logic [31:0] resume;
    logic [31:0] start;
  } tbl_wr_t;

  typedef struct packed {
    logic [1:0]  state;
    logic [31:0] resume;
    logic [31:0] start;
  } tbl_rd_t;

endpackage

// File: sv/rrts_alu.sv
module rrts_alu (
  input  rrts_pkg::alu_req_t req,
  output rrts_pkg::alu_rsp_t rsp
);
  import rrts_pkg::*;

  logic [32:0] total;

  // Subtract as a + ~b + 1; carry out then means a >= b.
  assign total = {1'b0, req.a} + {1'b0, (req.sub ? ~req.b : req.b)} + {32'd0, req.sub};
  assign rsp.sum   = total[31:0];
  assign rsp.carry = total[32];

endmodule

// File: sv/rrts_table.sv
module rrts_table #(
  parameter int SLOTS = rrts_pkg::SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [$clog2(SLOTS)-1:0]   raddr,
  input  logic [$clog2(SLOTS)-1:0]   waddr,
  input  rrts_pkg::tbl_wr_t          wr,
  output rrts_pkg::tbl_rd_t          rd
);
  import rrts_pkg::*;

  logic [1:0]  mem_state  [SLOTS];
  logic [31:0] mem_resume [SLOTS];
  logic [31:0] mem_start  [SLOTS];

  logic [SLOTS-1:0] vld_state;
  logic [SLOTS-1:0] vld_resume;
  logic [SLOTS-1:0] vld_start;

  logic [1:0]  q_state;
  logic [31:0] q_resume;
  logic [31:0] q_start;
  logic        q_vld_state;
  logic        q_vld_resume;
  logic        q_vld_start;
  logic        q_root;

  always_ff @(posedge clk) begin
    if (wr.we_state) begin
      mem_state[waddr] <= wr.state;
    end
    if (wr.we_resume) begin
      mem_resume[waddr] <= wr.resume;
    end
    if (wr.we_start) begin
      mem_start[waddr] <= wr.start;
    end
  end

  always_ff @(posedge clk) begin
    q_state  <= mem_state[raddr];
    q_resume <= mem_resume[raddr];
    q_start  <= mem_start[raddr];
  end

  // An entry never written reads as its reset value.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_state    <= '0;
      vld_resume   <= '0;
      vld_start    <= '0;
      q_vld_state  <= 1'b0;
      q_vld_resume <= 1'b0;
      q_vld_start  <= 1'b0;
      q_root       <= 1'b0;
    end else begin
      if (wr.we_state) begin
        vld_state[waddr] <= 1'b1;
      end
      if (wr.we_resume) begin
        vld_resume[waddr] <= 1'b1;
      end
      if (wr.we_start) begin
        vld_start[waddr] <= 1'b1;
      end
      q_vld_state  <= vld_state[raddr];
      q_vld_resume <= vld_resume[raddr];
      q_vld_start  <= vld_start[raddr];
      q_root       <= (raddr == '0);
    end
  end

  always_comb begin
    rd.state  = q_vld_state ? q_state : (q_root ? ST_READY : ST_FREE);
    rd.resume = q_vld_resume ? q_resume : (q_root ? 32'd1 : 32'd0);
    rd.start  = q_vld_start ? q_start : 32'd0;
  end

endmodule

// File: sv/rrts_seq.sv
module rrts_seq #(
  parameter int SLOTS = rrts_pkg::SLOTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2:0]               command,
  input  logic [3:0]               target_slot,
  input  logic [20:0]              stack_request,
  input  logic [31:0]              now_ms,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [2:0]               status,
  output logic [3:0]               running_slot,
  output logic                     switched,
  output logic [3:0]               result_slot,
  output logic [20:0]              granted_stack,
  output logic                     hog_flag,
  output logic [31:0]              held_ms,
  output logic [1:0]               target_state,
  output logic [31:0]              target_resumes,
  output logic [4:0]               ready_count,
  output logic [31:0]              total_switches,
  input  rrts_pkg::cfg_t           cfg,
  output rrts_pkg::alu_req_t       alu_req,
  input  rrts_pkg::alu_rsp_t       alu_rsp,
  output logic [$clog2(SLOTS)-1:0] raddr,
  output logic [$clog2(SLOTS)-1:0] waddr,
  output rrts_pkg::tbl_wr_t        wr,
  input  rrts_pkg::tbl_rd_t        rd
);
  import rrts_pkg::*;

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int RCNT_W = $clog2(SLOTS + 1);
  localparam logic [SLOT_W-1:0] LAST = SLOT_W'(SLOTS - 1);

  typedef enum logic [14:0] {
    S_IDLE  = 15'h0001,
    S_YRD   = 15'h0002,
    S_YSPAN = 15'h0004,
    S_YHOG  = 15'h0008,
    S_SCAN  = 15'h0010,
    S_POST  = 15'h0020,
    S_SWRD  = 15'h0040,
    S_SWRES = 15'h0080,
    S_SWTOT = 15'h0100,
    S_JCHK  = 15'h0200,
    S_QCHK  = 15'h0400,
    S_CMIN  = 15'h0800,
    S_CMAX  = 15'h1000,
    S_CRND  = 15'h2000,
    S_DONE  = 15'h4000
  } state_t;

  state_t state;

  // latched command
  logic [2:0]  op;
  logic [3:0]  tgt;
  logic [31:0] tstamp;
  logic [20:0] stack;

  // scheduler state
  logic [SLOT_W-1:0] cur;
  logic [31:0]       sw_total;
  logic [7:0]        hog_reports;
  logic [RCNT_W-1:0] ready_cnt;

  // yield and scan work registers
  logic [31:0]       span;
  logic              start_nz;
  logic [SLOT_W-1:0] ptr;
  logic [SLOT_W-1:0] cnt;
  logic              pend;
  logic [SLOT_W-1:0] pend_ptr;
  logic [1:0]        want;
  logic              found;
  logic [SLOT_W-1:0] fslot;

  // result under construction
  logic [2:0]  res_status;
  logic        res_switched;
  logic [3:0]  res_rslot;
  logic [20:0] res_granted;
  logic        res_hog;
  logic [31:0] res_held;
  logic [1:0]  res_tstate;
  logic [31:0] res_tres;

  logic [SLOT_W-1:0] tslot;
  logic              hit;
  logic              tgt_oob;
  logic              resume_sat;

  function automatic logic [SLOT_W-1:0] step(input logic [SLOT_W-1:0] p);
    return (p == LAST) ? '0 : p + 1'b1;
  endfunction

  assign tslot      = SLOT_W'(tgt);
  assign hit        = pend && (rd.state == want);
  assign tgt_oob    = (32'(target_slot) >= 32'(SLOTS));
  assign resume_sat = alu_rsp.carry;
  assign in_ready   = (state == S_IDLE);

  always_comb begin
    raddr        = cur;
    waddr        = cur;
    wr.we_state  = 1'b0;
    wr.we_resume = 1'b0;
    wr.we_start  = 1'b0;
    wr.state     = ST_FREE;
    wr.resume    = 32'd0;
    wr.start     = tstamp;
    alu_req.sub  = 1'b0;
    alu_req.a    = 32'd0;
    alu_req.b    = 32'd0;
    unique case (state)
      S_IDLE: begin
        raddr = (command == CMD_YIELD) ? cur : SLOT_W'(target_slot);
      end
      S_YSPAN: begin
        alu_req.sub = 1'b1;
        alu_req.a   = tstamp;
        alu_req.b   = rd.start;
      end
      S_YHOG: begin
        alu_req.sub = 1'b1;
        alu_req.a   = span;
        alu_req.b   = cfg.hog_limit;
      end
      S_SCAN: begin
        raddr = ptr;
      end
      S_POST: begin
        unique case (op)
          CMD_CREATE: begin
            waddr        = fslot;
            wr.we_state  = found;
            wr.we_resume = found;
            wr.we_start  = found;
            wr.state     = ST_READY;
            wr.start     = 32'd0;
          end
          CMD_EXIT: begin
            wr.we_state = found;
            wr.state    = ST_DEAD;
          end
          default: begin
            // lone ready thread: restart its timer
            wr.we_start = !found;
          end
        endcase
      end
      S_SWRD: begin
        raddr = fslot;
      end
      S_SWRES: begin
        alu_req.a    = rd.resume;
        alu_req.b    = 32'd1;
        waddr        = fslot;
        wr.we_resume = 1'b1;
        wr.we_start  = 1'b1;
        wr.resume    = resume_sat ? rd.resume : alu_rsp.sum;
      end
      S_SWTOT: begin
        alu_req.a = sw_total;
        alu_req.b = 32'd1;
      end
      S_JCHK: begin
        waddr       = tslot;
        wr.we_state = (rd.state == ST_DEAD) && (tslot != cur);
        wr.state    = ST_FREE;
      end
      S_CMIN: begin
        alu_req.sub = 1'b1;
        alu_req.a   = {11'd0, stack};
        alu_req.b   = {11'd0, cfg.stack_min};
      end
      S_CMAX: begin
        alu_req.sub = 1'b1;
        alu_req.a   = {11'd0, cfg.stack_max};
        alu_req.b   = {11'd0, stack};
      end
      S_CRND: begin
        alu_req.a = {11'd0, stack};
        alu_req.b = STACK_ROUND;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cur         <= '0;
      sw_total    <= 32'd0;
      hog_reports <= 8'd0;
      ready_cnt   <= RCNT_W'(1);
      out_valid   <= 1'b0;
      pend        <= 1'b0;
    end else begin
      // a result loaded in S_DONE takes over the output register instead
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op           <= command;
            tgt          <= target_slot;
            tstamp       <= now_ms;
            stack        <= (stack_request == 21'd0) ? cfg.stack_default : stack_request;
            res_status   <= STS_OK;
            res_switched <= 1'b0;
            res_rslot    <= target_slot;
            res_granted  <= 21'd0;
            res_hog      <= 1'b0;
            res_held     <= 32'd0;
            res_tstate   <= ST_FREE;
            res_tres     <= 32'd0;
            case (command)
              CMD_YIELD:  state <= S_YSPAN;
              CMD_CREATE: state <= S_CMIN;
              CMD_EXIT: begin
                if (cur == '0) begin
                  res_status <= STS_ROOT_EXIT;
                  state      <= S_DONE;
                end else begin
                  ptr   <= step(cur);
                  cnt   <= '0;
                  pend  <= 1'b0;
                  want  <= ST_READY;
                  state <= S_SCAN;
                end
              end
              CMD_JOIN, CMD_QUERY: begin
                if (tgt_oob) begin
                  res_status <= STS_BAD_TARGET;
                  state      <= S_DONE;
                end else begin
                  state <= (command == CMD_JOIN) ? S_JCHK : S_QCHK;
                end
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_YRD: state <= S_YSPAN;
        S_YSPAN: begin
          span     <= alu_rsp.sum;
          start_nz <= (rd.start != 32'd0);
          state    <= S_YHOG;
        end
        S_YHOG: begin
          if (start_nz && (hog_reports < cfg.hog_report_limit) && alu_rsp.carry &&
              (ready_cnt >= RCNT_W'(2))) begin
            hog_reports <= hog_reports + 8'd1;
            res_hog     <= 1'b1;
            res_held    <= span;
          end
          ptr   <= step(cur);
          cnt   <= '0;
          pend  <= 1'b0;
          want  <= ST_READY;
          state <= S_SCAN;
        end
        S_SCAN: begin
          // one read issued per cycle, its data checked the cycle after
          if (hit) begin
            found <= 1'b1;
            fslot <= pend_ptr;
            pend  <= 1'b0;
            state <= S_POST;
          end else if (cnt == LAST) begin
            pend <= 1'b0;
            if (!pend) begin
              found <= 1'b0;
              state <= S_POST;
            end
          end else begin
            pend     <= 1'b1;
            pend_ptr <= ptr;
            ptr      <= step(ptr);
            cnt      <= cnt + 1'b1;
          end
        end
        S_POST: begin
          unique case (op)
            CMD_CREATE: begin
              if (found) begin
                ready_cnt   <= ready_cnt + 1'b1;
                res_rslot   <= 4'(fslot);
                res_granted <= stack;
              end else begin
                res_status <= STS_NO_FREE;
                res_rslot  <= 4'd0;
              end
              state <= S_DONE;
            end
            CMD_EXIT: begin
              if (found) begin
                ready_cnt <= ready_cnt - 1'b1;
                state     <= S_SWRD;
              end else begin
                res_status <= STS_NONE_READY;
                state      <= S_DONE;
              end
            end
            default: begin
              state <= found ? S_SWRD : S_DONE;
            end
          endcase
        end
        S_SWRD: state <= S_SWRES;
        S_SWRES: begin
          cur          <= fslot;
          res_switched <= 1'b1;
          state        <= S_SWTOT;
        end
        S_SWTOT: begin
          if (!alu_rsp.carry) begin
            sw_total <= alu_rsp.sum;
          end
          state <= S_DONE;
        end
        S_JCHK: begin
          if ((rd.state == ST_FREE) || (tslot == cur)) begin
            res_status <= STS_BAD_TARGET;
            state      <= S_DONE;
          end else if (rd.state == ST_DEAD) begin
            state <= S_DONE;
          end else if (ready_cnt < RCNT_W'(2)) begin
            res_status <= STS_JOIN_NEVER;
            state      <= S_DONE;
          end else begin
            res_status <= STS_JOIN_PENDING;
            state      <= S_YRD;
          end
        end
        S_QCHK: begin
          res_tstate <= rd.state;
          res_tres   <= (rd.state == ST_FREE) ? 32'd0 : rd.resume;
          state      <= S_DONE;
        end
        S_CMIN: begin
          if (!alu_rsp.carry) begin
            stack <= cfg.stack_min;
          end
          state <= S_CMAX;
        end
        S_CMAX: begin
          if (!alu_rsp.carry) begin
            stack <= cfg.stack_max;
          end
          state <= S_CRND;
        end
        S_CRND: begin
          stack <= alu_rsp.sum[21] ? GRANT_SAT : {alu_rsp.sum[20:4], 4'd0};
          ptr   <= SLOT_W'(1);
          cnt   <= '0;
          pend  <= 1'b0;
          want  <= ST_FREE;
          state <= S_SCAN;
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            status         <= res_status;
            running_slot   <= 4'(cur);
            switched       <= res_switched;
            result_slot    <= res_rslot;
            granted_stack  <= res_granted;
            hog_flag       <= res_hog;
            held_ms        <= res_held;
            target_state   <= res_tstate;
            target_resumes <= res_tres;
            ready_count    <= 5'(ready_cnt);
            total_switches <= sw_total;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: sv/round_robin_thread_slot_scheduler_top.sv
// Channel   Signals                                      Direction
// in        in_valid/in_ready, command..now_ms           command item into the block
// out       out_valid/out_ready, status..total_switches  one result item per command
// cfg       cfg_valid/cfg_ready, cfg_index, cfg_data     register write, always ready
//
// One command at a time. Root exit, an out-of-range target or an ignored command goes
// straight to its result, a query reads one table entry first. Yield, exit, pending join and
// create walk the slot table one slot per cycle through its single read port; the longest is
// a pending join that switches.
// A finished result waits in the output register; the next command is accepted meanwhile,
// and its result holds in the last cycle until the register is free.
// Reset restores register defaults and the slot table's reset contents at once, no sweep.
module round_robin_thread_slot_scheduler_top #(
  parameter int SLOTS = rrts_pkg::SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  command,
  input  logic [3:0]  target_slot,
  input  logic [20:0] stack_request,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [3:0]  running_slot,
  output logic        switched,
  output logic [3:0]  result_slot,
  output logic [20:0] granted_stack,
  output logic        hog_flag,
  output logic [31:0] held_ms,
  output logic [1:0]  target_state,
  output logic [31:0] target_resumes,
  output logic [4:0]  ready_count,
  output logic [31:0] total_switches,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import rrts_pkg::*;

  localparam int SLOT_W = $clog2(SLOTS);

  cfg_t              cfg;
  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;
  tbl_wr_t           wr;
  tbl_rd_t           rd;
  logic [SLOT_W-1:0] raddr;
  logic [SLOT_W-1:0] waddr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_STACK_DEFAULT: cfg.stack_default    <= cfg_data[20:0];
        CFG_STACK_MIN:     cfg.stack_min        <= cfg_data[20:0];
        CFG_STACK_MAX:     cfg.stack_max        <= cfg_data[20:0];
        CFG_HOG_LIMIT:     cfg.hog_limit        <= cfg_data;
        CFG_HOG_REPORTS:   cfg.hog_report_limit <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  rrts_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  rrts_table #(.SLOTS(SLOTS)) u_table (
    .clk   (clk),
    .rst   (rst),
    .raddr (raddr),
    .waddr (waddr),
    .wr    (wr),
    .rd    (rd)
  );

  rrts_seq #(.SLOTS(SLOTS)) u_seq (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .target_slot    (target_slot),
    .stack_request  (stack_request),
    .now_ms         (now_ms),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .running_slot   (running_slot),
    .switched       (switched),
    .result_slot    (result_slot),
    .granted_stack  (granted_stack),
    .hog_flag       (hog_flag),
    .held_ms        (held_ms),
    .target_state   (target_state),
    .target_resumes (target_resumes),
    .ready_count    (ready_count),
    .total_switches (total_switches),
    .cfg            (cfg),
    .alu_req        (alu_req),
    .alu_rsp        (alu_rsp),
    .raddr          (raddr),
    .waddr          (waddr),
    .wr             (wr),
    .rd             (rd)
  );

endmodule

// File: sv/rrts_checker.sv
`include "round_robin_thread_slot_scheduler_top_assert.svh"

module rrts_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [3:0]  running_slot,
  input logic        switched,
  input logic [20:0] granted_stack,
  input logic [4:0]  ready_count
);
  import rrts_pkg::*;

  // a stalled result holds
  `RRTS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                    out_valid && $stable(status) && $stable(running_slot))

  // the root thread never leaves the ready set
  `RRTS_ASSERT_IMP(a_root_ready, out_valid, ready_count != 5'd0)

  // only a successful switch or a pending join changes the running slot
  `RRTS_ASSERT_IMP(a_switch_status, out_valid && switched,
                   status == STS_OK || status == STS_JOIN_PENDING)

  // grants are whole 16-byte units
  `RRTS_ASSERT_IMP(a_grant_align, out_valid, granted_stack[3:0] == 4'd0)

endmodule

bind round_robin_thread_slot_scheduler_top rrts_checker u_rrts_checker (.*);

// File: bench/tb_round_robin_thread_slot_scheduler_top.sv
`timescale 1ns / 100ps

module tb_round_robin_thread_slot_scheduler_top;
  import rrts_pkg::*;

  localparam int NSLOT = 16;
  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT = 5000;

  // command codes the block ignores
  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
  localparam logic [2:0] CFG_UNUSED = 3'd7;

  typedef struct packed {
    logic [2:0]  command;
    logic [3:0]  target_slot;
    logic [20:0] stack_request;
    logic [31:0] now_ms;
  } sched_cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  running_slot;
    logic        switched;
    logic [3:0]  result_slot;
    logic [20:0] granted_stack;
    logic        hog_flag;
    logic [31:0] held_ms;
    logic [1:0]  target_state;
    logic [31:0] target_resumes;
    logic [4:0]  ready_count;
    logic [31:0] total_switches;
  } sched_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  command = '0;
  logic [3:0]  target_slot = '0;
  logic [20:0] stack_request = '0;
  logic [31:0] now_ms = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [3:0]  running_slot;
  logic        switched;
  logic [3:0]  result_slot;
  logic [20:0] granted_stack;
  logic        hog_flag;
  logic [31:0] held_ms;
  logic [1:0]  target_state;
  logic [31:0] target_resumes;
  logic [4:0]  ready_count;
  logic [31:0] total_switches;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  round_robin_thread_slot_scheduler_top #(.SLOTS(NSLOT)) dut (.*);

  always #1 clk = ~clk;

  // scheduler shadow
  cfg_t        cfg_m;
  logic [1:0]  slot_st [NSLOT];
  logic [31:0] slot_resumes [NSLOT];
  logic [31:0] slot_start [NSLOT];
  logic [3:0]  run_slot;
  logic [31:0] switch_cnt;
  logic [7:0]  hog_cnt;

  sched_cmd_t    pending_cmds [$];
  sched_result_t expected_results [$];
  sched_cmd_t    cur_cmd;
  int            cmds_issued = 0;
  int            cmds_accepted = 0;
  int            errors = 0;
  int            stall_cycles = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  logic [31:0]   clock_ms;

  function automatic logic [31:0] sat_inc32(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic logic [4:0] ready_slots();
    logic [4:0] n;
    n = '0;
    for (int i = 0; i < NSLOT; i++)
      if (slot_st[i] == ST_READY) n++;
    return n;
  endfunction

  // returns NSLOT when no slot is ready
  function automatic int next_ready_after(int from);
    for (int i = 1; i <= NSLOT; i++)
      if (slot_st[(from + i) % NSLOT] == ST_READY) return (from + i) % NSLOT;
    return NSLOT;
  endfunction

  function automatic void resume_slot(int nxt, logic [31:0] now);
    switch_cnt = sat_inc32(switch_cnt);
    slot_resumes[nxt] = sat_inc32(slot_resumes[nxt]);
    slot_start[nxt] = now;
    run_slot = 4'(nxt);
  endfunction

  function automatic void yield_cpu(logic [31:0] now, inout sched_result_t r);
    logic [31:0] start_ms;
    logic [31:0] span;
    int cur;
    int nxt;
    cur = run_slot;
    start_ms = slot_start[cur];
    span = now - start_ms;
    // a zero start time means the slot was never timed
    if (start_ms != 0 && hog_cnt < cfg_m.hog_report_limit && span >= cfg_m.hog_limit &&
        ready_slots() >= 5'd2) begin
      hog_cnt++;
      r.hog_flag = 1'b1;
      r.held_ms = span;
    end
    nxt = next_ready_after(cur);
    if (nxt >= NSLOT || nxt == cur) begin
      slot_start[cur] = now;
    end else begin
      resume_slot(nxt, now);
      r.switched = 1'b1;
    end
  endfunction

  function automatic sched_result_t schedule_cmd(sched_cmd_t c);
    sched_result_t r;
    logic [31:0] grant;
    logic [1:0] prev;
    int free_slot;
    int cur;
    int nxt;
    r = '0;
    r.result_slot = c.target_slot;
    case (c.command)
      CMD_YIELD: yield_cpu(c.now_ms, r);
      CMD_CREATE: begin
        grant = {11'd0, c.stack_request};
        if (grant == 0) grant = {11'd0, cfg_m.stack_default};
        if (grant < {11'd0, cfg_m.stack_min}) grant = {11'd0, cfg_m.stack_min};
        if (grant > {11'd0, cfg_m.stack_max}) grant = {11'd0, cfg_m.stack_max};
        grant = (grant + STACK_ROUND) & ~STACK_ROUND;
        if (grant > 32'h1F_FFFF) grant = {11'd0, GRANT_SAT};
        free_slot = NSLOT;
        for (int i = NSLOT - 1; i >= 1; i--)
          if (slot_st[i] == ST_FREE) free_slot = i;
        if (free_slot == NSLOT) begin
          r.status = STS_NO_FREE;
          r.result_slot = '0;
        end else begin
          slot_st[free_slot] = ST_READY;
          slot_resumes[free_slot] = '0;
          slot_start[free_slot] = '0;
          r.result_slot = 4'(free_slot);
          r.granted_stack = grant[20:0];
        end
      end
      CMD_EXIT: begin
        cur = run_slot;
        if (cur == 0) begin
          r.status = STS_ROOT_EXIT;
        end else begin
          prev = slot_st[cur];
          slot_st[cur] = ST_DEAD;
          nxt = next_ready_after(cur);
          if (nxt >= NSLOT) begin
            slot_st[cur] = prev;
            r.status = STS_NONE_READY;
          end else begin
            resume_slot(nxt, c.now_ms);
            r.switched = 1'b1;
          end
        end
      end
      CMD_JOIN: begin
        if (slot_st[c.target_slot] == ST_FREE || c.target_slot == run_slot) begin
          r.status = STS_BAD_TARGET;
        end else if (slot_st[c.target_slot] == ST_DEAD) begin
          slot_st[c.target_slot] = ST_FREE;
        end else if (ready_slots() < 5'd2) begin
          r.status = STS_JOIN_NEVER;
        end else begin
          r.status = STS_JOIN_PENDING;
          yield_cpu(c.now_ms, r);
        end
      end
      CMD_QUERY: begin
        r.target_state = slot_st[c.target_slot];
        r.target_resumes = (slot_st[c.target_slot] == ST_FREE) ? '0 :
                           slot_resumes[c.target_slot];
      end
      default: ;
    endcase
    r.running_slot = run_slot;
    r.ready_count = ready_slots();
    r.total_switches = switch_cnt;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  function automatic void queue_cmd(logic [2:0] cmd, logic [3:0] tgt, logic [20:0] req,
                                    logic [31:0] now);
    pending_cmds.push_back(sched_cmd_t'{cmd, tgt, req, now});
    cmds_issued++;
  endfunction

  // command driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(schedule_cmd(cur_cmd));
        cmds_accepted++;
      end
      // hold a presented item until it is taken
      if (!in_valid || in_ready) begin
        if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_cmd = pending_cmds.pop_front();
          command <= cur_cmd.command;
          target_slot <= cur_cmd.target_slot;
          stack_request <= cur_cmd.stack_request;
          now_ms <= cur_cmd.now_ms;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : check_results
    sched_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result item with no command outstanding");
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", 32'(want.status), 32'(status));
          check_field("running_slot", 32'(want.running_slot), 32'(running_slot));
          check_field("switched", 32'(want.switched), 32'(switched));
          check_field("result_slot", 32'(want.result_slot), 32'(result_slot));
          check_field("granted_stack", 32'(want.granted_stack), 32'(granted_stack));
          check_field("hog_flag", 32'(want.hog_flag), 32'(hog_flag));
          check_field("held_ms", want.held_ms, held_ms);
          check_field("target_state", 32'(want.target_state), 32'(target_state));
          check_field("target_resumes", want.target_resumes, target_resumes);
          check_field("ready_count", 32'(want.ready_count), 32'(ready_count));
          check_field("total_switches", want.total_switches, total_switches);
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_STACK_DEFAULT: cfg_m.stack_default = data[20:0];
      CFG_STACK_MIN:     cfg_m.stack_min = data[20:0];
      CFG_STACK_MAX:     cfg_m.stack_max = data[20:0];
      CFG_HOG_LIMIT:     cfg_m.hog_limit = data;
      CFG_HOG_REPORTS:   cfg_m.hog_report_limit = data[7:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // wait until every command has been answered, then let the block settle
  task automatic drain();
    @(negedge clk);
    while (cmds_issued != cmds_accepted || expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic gen_random(input int n, input int create_pct);
    int pick;
    int dead_slots [$];
    logic [2:0] cmd;
    logic [3:0] tgt;
    logic [20:0] req;
    logic [31:0] now;
    for (int k = 0; k < n; k++) begin
      // pick each command against the state left by the previous one
      @(negedge clk);
      while (cmds_issued != cmds_accepted) @(negedge clk);
      pick = $urandom_range(0, 99);
      tgt = 4'($urandom);
      req = 21'($urandom);
      case ($urandom_range(0, 19))
        0: now = '0;
        1: now = $urandom;
        2: now = 32'hFFFF_FFFF;
        default: begin
          clock_ms = clock_ms + $urandom_range(0, 1500);
          now = clock_ms;
        end
      endcase
      if (pick < 30) begin
        cmd = CMD_YIELD;
      end else if (pick < 30 + create_pct) begin
        cmd = CMD_CREATE;
        case ($urandom_range(0, 5))
          0: req = '0;
          1: req = 21'($urandom);
          2: req = 21'($urandom_range(0, 64));
          3: req = 21'h1F_FFFF - 21'($urandom_range(0, 32));
          4: req = cfg_m.stack_min + 21'($urandom_range(0, 32)) - 21'd16;
          default: req = cfg_m.stack_max + 21'($urandom_range(0, 32)) - 21'd16;
        endcase
      end else if (pick < 50 + create_pct) begin
        cmd = CMD_EXIT;
      end else if (pick < 66 + create_pct) begin
        cmd = CMD_JOIN;
        // mostly reap a dead slot
        dead_slots.delete();
        for (int i = 0; i < NSLOT; i++)
          if (slot_st[i] == ST_DEAD) dead_slots.push_back(i);
        if (dead_slots.size() != 0 && $urandom_range(0, 3) != 0)
          tgt = 4'(dead_slots[$urandom_range(0, dead_slots.size() - 1)]);
      end else if (pick < 96) begin
        cmd = CMD_QUERY;
      end else begin
        cmd = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
      end
      queue_cmd(cmd, tgt, req, now);
    end
  endtask

  initial begin : stimulus
    cfg_m = CFG_RESET;
    for (int i = 0; i < NSLOT; i++) begin
      slot_st[i] = ST_FREE;
      slot_resumes[i] = '0;
      slot_start[i] = '0;
    end
    slot_st[0] = ST_READY;
    slot_resumes[0] = 32'd1;
    run_slot = '0;
    switch_cnt = '0;
    hog_cnt = '0;
    clock_ms = 32'd10000;

    send_idle_pct = 15;
    recv_idle_pct = 87;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: lone root, errors, stack clamping, hog and wraparound, dead slots
    queue_cmd(CMD_QUERY, 4'd0, 21'd0, 32'd0);
    queue_cmd(CMD_QUERY, 4'hF, 21'h1F_FFFF, 32'hFFFF_FFFF);
    queue_cmd(CMD_YIELD, 4'd0, 21'd0, 32'd0);
    queue_cmd(CMD_EXIT, 4'd0, 21'd0, 32'd10);
    queue_cmd(CMD_JOIN, 4'd0, 21'd0, 32'd20);
    queue_cmd(CMD_JOIN, 4'd9, 21'd0, 32'd30);
    queue_cmd(CMD_CREATE, 4'd0, 21'd0, 32'd40);
    queue_cmd(CMD_CREATE, 4'd0, 21'd1, 32'd50);
    queue_cmd(CMD_CREATE, 4'd0, 21'h1F_FFFF, 32'd60);
    queue_cmd(CMD_CREATE, 4'd0, 21'd4097, 32'd70);
    queue_cmd(CMD_YIELD, 4'd0, 21'd0, 32'd5000);
    queue_cmd(CMD_JOIN, 4'd2, 21'd0, 32'd7000);
    queue_cmd(CMD_EXIT, 4'd0, 21'd0, 32'd8000);
    queue_cmd(CMD_QUERY, 4'd2, 21'd0, 32'd8100);
    queue_cmd(CMD_JOIN, 4'd3, 21'd0, 32'd8200);
    queue_cmd(CMD_JOIN, 4'd2, 21'd0, 32'd8300);
    queue_cmd(CMD_YIELD, 4'd0, 21'd0, 32'hFFFF_FFF0);
    queue_cmd(CMD_YIELD, 4'd0, 21'd0, 32'd5);
    queue_cmd(CMD_CREATE, 4'd0, 21'd65535, 32'd9000);
    queue_cmd(CMD_UNUSED_LO, 4'hA, 21'h15_5555, 32'hAAAA_AAAA);
    queue_cmd(CMD_UNUSED_HI, 4'h5, 21'h0A_AAAA, 32'h5555_5555);
    drain();

    gen_random(200, 20);
    drain();

    send_idle_pct = 87;
    recv_idle_pct = 15;
    write_reg(CFG_STACK_DEFAULT, {11'($urandom), 21'd16});
    write_reg(CFG_STACK_MIN, 32'd16);
    write_reg(CFG_STACK_MAX, 32'h001F_FFFF);
    write_reg(CFG_HOG_LIMIT, 32'd0);
    write_reg(CFG_HOG_REPORTS, {24'($urandom), 8'd255});
    gen_random(200, 30);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // min above max: max wins
    write_reg(CFG_STACK_DEFAULT, 32'h001F_FFFF);
    write_reg(CFG_STACK_MIN, 32'h0010_0000);
    write_reg(CFG_STACK_MAX, {11'h7FF, 21'd16});
    write_reg(CFG_HOG_LIMIT, 32'hFFFF_FFFF);
    write_reg(CFG_HOG_REPORTS, 32'd0);
    gen_random(100, 15);
    drain();

    write_reg(CFG_STACK_DEFAULT, {11'($urandom), 21'($urandom_range(16, 1048576))});
    write_reg(CFG_STACK_MIN, {11'($urandom), 21'($urandom_range(16, 8192))});
    write_reg(CFG_STACK_MAX, {11'($urandom), 21'($urandom_range(4096, 1048576))});
    write_reg(CFG_HOG_LIMIT, $urandom_range(0, 3000));
    write_reg(CFG_HOG_REPORTS, $urandom);
    write_reg(CFG_UNUSED, $urandom);
    gen_random(150, 25);
    drain();

    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/rrts_pkg.sv
sv/rrts_alu.sv
sv/rrts_table.sv
sv/rrts_seq.sv
sv/round_robin_thread_slot_scheduler_top.sv
sv/rrts_checker.sv
bench/tb_round_robin_thread_slot_scheduler_top.sv
